/* rtl/core/rpn_stack_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shared concurrent assertion shorthands for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RSE_ASSERT_IMPLY(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, disabled while reset is asserted
`define RSE_ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

/* rtl/core/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// Types, codes and helpers shared by the RPN stack evaluator modules.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int VALUE_W         = 32;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 3;
  localparam int DEPTH_W         = 8;
  // token queue between front and back, power of two
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [MODE_W-1:0] MODE_NUM = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd4;
  localparam logic [MODE_W-1:0] MODE_END = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DEPTH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd4;

  localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_END,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } token_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_READ,
    EX_MUL,
    EX_DIV
  } ex_state_t;

  // clamp a 48-bit signed value to the Q16.16 range
  function automatic logic signed [VALUE_W-1:0] sat48(input logic signed [47:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > SAT_HI) begin
      r = Q_MAX;
    end else if (v < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/rse_front.sv */
// ----------------------------------------------------------------------------
// rse_front
// Accepts tokens and decodes the mode field into an operation class.
// ----------------------------------------------------------------------------
module rse_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rse_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [rse_pkg::VALUE_W-1:0]  in_number_value,
  output logic                                q_valid,
  output rse_pkg::token_t                     q_data,
  input  logic                                q_ready
);
  import rse_pkg::*;

  op_t op;

  always_comb begin
    case (in_mode)
      MODE_NUM: op = OP_PUSH;
      MODE_ADD: op = OP_ADD;
      MODE_SUB: op = OP_SUB;
      MODE_MUL: op = OP_MUL;
      MODE_DIV: op = OP_DIV;
      MODE_END: op = OP_END;
      default:  op = OP_NOP;
    endcase
  end

  assign q_valid      = in_valid;
  assign in_ready     = q_ready;
  assign q_data.op    = op;
  assign q_data.value = in_number_value;

endmodule

/* rtl/core/rse_queue.sv */
// ----------------------------------------------------------------------------
// rse_queue
// Short token queue that decouples the decoder from the execution unit.
// ----------------------------------------------------------------------------
module rse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  rse_pkg::token_t wr_data,
  output logic            wr_ready,
  output logic            rd_valid,
  output rse_pkg::token_t rd_data,
  input  logic            rd_ready
);
  import rse_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FILL_ONE = CNT_W'(1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  token_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push, pop;

  assign wr_ready = (fill_r != FILL_MAX);
  assign rd_valid = (fill_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_ONE : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_ONE;
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/rse_div.sv */
// ----------------------------------------------------------------------------
// rse_div
// Iterative Q16.16 divider, two restoring quotient bits per cycle.
// ----------------------------------------------------------------------------
module rse_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rse_pkg::VALUE_W-1:0] dividend,
  input  logic signed [rse_pkg::VALUE_W-1:0] divisor,
  output logic                               done,
  output logic signed [rse_pkg::VALUE_W-1:0] quot
);
  import rse_pkg::*;

  localparam int FRAC_W = 16;
  localparam int DVD_W  = VALUE_W + FRAC_W;
  localparam int STEPS  = 2;
  localparam int ITERS  = DVD_W / STEPS;
  localparam int ITER_W = $clog2(ITERS + 1);
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(33'h0_7FFF_FFFF);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(33'h0_8000_0000);

  logic [ITER_W-1:0]  iter_r;
  logic               done_r;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]   qd_r, qd_nxt;
  logic [VALUE_W-1:0] dsr_r;
  logic               neg_r;
  logic [VALUE_W-1:0] mag_a, mag_b;

  assign mag_a = dividend[VALUE_W-1] ? (VALUE_W'(0) - dividend) : dividend;
  assign mag_b = divisor[VALUE_W-1] ? (VALUE_W'(0) - divisor) : divisor;

  // partial remainder stays below the divisor, so it fits in 32 bits
  always_comb begin
    logic [VALUE_W:0]   shifted;
    logic [VALUE_W+1:0] trial;
    rem_nxt = rem_r;
    qd_nxt  = qd_r;
    for (int i = 0; i < STEPS; i++) begin
      shifted = {rem_nxt, qd_nxt[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_r};
      if (!trial[VALUE_W+1]) begin
        rem_nxt = trial[VALUE_W-1:0];
        qd_nxt  = {qd_nxt[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VALUE_W-1:0];
        qd_nxt  = {qd_nxt[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (iter_r == ITER_W'(1));
      if (start) begin
        iter_r <= ITER_W'(ITERS);
      end else if (iter_r != '0) begin
        iter_r <= iter_r - ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qd_r  <= {mag_a, FRAC_W'(0)};
      dsr_r <= mag_b;
      neg_r <= dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
    end else if (iter_r != '0) begin
      rem_r <= rem_nxt;
      qd_r  <= qd_nxt;
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = (qd_r > POS_LIM) ? Q_MAX : $signed(qd_r[VALUE_W-1:0]);
    end else begin
      quot = (qd_r > NEG_LIM) ? Q_MIN : $signed(VALUE_W'(0) - qd_r[VALUE_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

/* rtl/core/rse_exec.sv */
// ----------------------------------------------------------------------------
// rse_exec
// Execution unit: operand stack, arithmetic and result register.
// ----------------------------------------------------------------------------
module rse_exec #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                tok_valid,
  input  rse_pkg::token_t                     tok,
  output logic                                tok_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rse_pkg::VALUE_W-1:0]  out_top_value,
  output logic [rse_pkg::STATUS_W-1:0]        out_status,
  output logic [rse_pkg::DEPTH_W-1:0]         out_depth,
  output logic                                out_expression_done
);
  import rse_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  ex_state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [STATUS_W-1:0]       fault_r, fault_nxt;
  logic signed [VALUE_W-1:0] tos_r, tos_nxt;
  op_t                       op_r, op_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_top_r, out_top_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [DEPTH_W-1:0]        out_depth_r, out_depth_nxt;
  logic                      out_done_r, out_done_nxt;

  // entries below the top; the top itself lives in tos_r
  logic signed [VALUE_W-1:0] stack_mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                      mem_we, mem_re;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;

  logic signed [63:0]        prod_r;
  logic signed [63:0]        prod_adj;
  logic signed [VALUE_W:0]   a33, b33, sum33;
  logic signed [VALUE_W-1:0] add_res, mul_res, div_quot;
  logic                      div_start, div_done;

  logic                      slot_free, take, is_arith, op_go;
  logic                      fin;
  logic signed [VALUE_W-1:0] fin_val;
  logic [STATUS_W-1:0]       fin_status;

  assign slot_free = ~out_valid_r | out_ready;
  assign tok_ready = (state_r == EX_IDLE) & slot_free;
  assign take      = tok_valid & tok_ready;
  assign is_arith  = tok.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
  assign op_go     = take & is_arith & (fault_r == ST_OK) & (count_r >= CNT_TWO);

  assign a33      = $signed({rd_data_r[VALUE_W-1], rd_data_r});
  assign b33      = $signed({tos_r[VALUE_W-1], tos_r});
  assign sum33    = (op_r == OP_SUB) ? a33 - b33 : a33 + b33;
  assign add_res  = sat48($signed({{15{sum33[VALUE_W]}}, sum33}));
  // shift toward zero: bias negative products before the arithmetic shift
  assign prod_adj = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
  assign mul_res  = sat48($signed(prod_adj[63:16]));

  rse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EX_IDLE: begin
        if (op_go) begin
          state_nxt = EX_READ;
        end
      end
      EX_READ: begin
        case (op_r)
          OP_MUL:  state_nxt = EX_MUL;
          OP_DIV:  state_nxt = (tos_r == '0) ? EX_IDLE : EX_DIV;
          default: state_nxt = EX_IDLE;
        endcase
      end
      EX_MUL: state_nxt = EX_IDLE;
      EX_DIV: begin
        if (div_done) begin
          state_nxt = EX_IDLE;
        end
      end
      default: state_nxt = EX_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    fault_nxt      = fault_r;
    tos_nxt        = tos_r;
    op_nxt         = op_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_top_nxt    = out_top_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    out_done_nxt   = out_done_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = ADDR_W'(count_r - CNT_ONE);
    mem_raddr      = ADDR_W'(count_r - CNT_TWO);
    div_start      = 1'b0;
    fin            = 1'b0;
    fin_val        = tos_r;
    fin_status     = ST_OK;

    case (state_r)
      EX_IDLE: begin
        if (take) begin
          case (tok.op)
            OP_PUSH: begin
              if (fault_r == ST_OK) begin
                if (count_r >= CNT_FULL) begin
                  fault_nxt = ST_OVERFLOW;
                end else begin
                  mem_we    = (count_r != '0);
                  tos_nxt   = tok.value;
                  count_nxt = count_r + CNT_ONE;
                end
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (fault_r == ST_OK) begin
                if (count_r < CNT_TWO) begin
                  fault_nxt = ST_UNDERFLOW;
                end else begin
                  mem_re = 1'b1;
                  op_nxt = tok.op;
                end
              end
            end
            OP_END: begin
              count_nxt = '0;
              fault_nxt = ST_OK;
            end
            default: ;
          endcase

          if (!op_go) begin
            out_valid_nxt  = 1'b1;
            out_done_nxt   = (tok.op == OP_END);
            out_depth_nxt  = DEPTH_W'(count_nxt);
            out_status_nxt = fault_nxt;
            out_top_nxt    = (count_nxt != '0) ? tos_nxt : '0;
            if (tok.op == OP_END) begin
              if (fault_r != ST_OK) begin
                out_status_nxt = fault_r;
                out_top_nxt    = '0;
              end else if (count_r != CNT_ONE) begin
                out_status_nxt = ST_BAD_DEPTH;
                out_top_nxt    = '0;
              end else begin
                out_status_nxt = ST_OK;
                out_top_nxt    = tos_r;
              end
            end
          end
        end
      end
      EX_READ: begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            fin     = 1'b1;
            fin_val = add_res;
          end
          OP_DIV: begin
            if (tos_r == '0) begin
              fin        = 1'b1;
              fin_val    = rd_data_r[VALUE_W-1] ? Q_MIN : Q_MAX;
              fin_status = ST_DIV_ZERO;
            end else begin
              div_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      EX_MUL: begin
        fin     = 1'b1;
        fin_val = mul_res;
      end
      EX_DIV: begin
        if (div_done) begin
          fin     = 1'b1;
          fin_val = div_quot;
        end
      end
      default: ;
    endcase

    // binary op result replaces the top, one entry popped
    if (fin) begin
      tos_nxt        = fin_val;
      count_nxt      = count_r - CNT_ONE;
      out_valid_nxt  = 1'b1;
      out_top_nxt    = fin_val;
      out_status_nxt = fin_status;
      out_depth_nxt  = DEPTH_W'(count_r - CNT_ONE);
      out_done_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EX_IDLE;
      count_r     <= '0;
      fault_r     <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    op_r         <= op_nxt;
    out_top_r    <= out_top_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
    out_done_r   <= out_done_nxt;
    if (state_r == EX_READ) begin
      prod_r <= rd_data_r * tos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= tos_r;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_top_value       = out_top_r;
  assign out_status          = out_status_r;
  assign out_depth           = out_depth_r;
  assign out_expression_done = out_done_r;

endmodule

/* rtl/core/rpn_stack_evaluator.sv */
// Push, end and unused tokens are handled in the execution unit's take step; add,
// subtract and divide by zero run take and read, multiply take, read and multiply, and
// divide take, read, 24 two-bit divider passes and finish. Accepted tokens are registered
// in a 2-entry token queue, which lets input transfers continue while the unit is busy.
// Synchronous active-low reset empties the stack, clears the fault and both channels;
// no clearing pass, the stack memory is written before it is read.
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix Q16.16 expression evaluator on a bounded operand stack.
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rse_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [rse_pkg::VALUE_W-1:0]  in_number_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rse_pkg::VALUE_W-1:0]  out_top_value,
  output logic [rse_pkg::STATUS_W-1:0]        out_status,
  output logic [rse_pkg::DEPTH_W-1:0]         out_depth,
  output logic                                out_expression_done
);
  import rse_pkg::*;

  logic   q_wr_valid, q_wr_ready;
  token_t q_wr_data;
  logic   q_rd_valid, q_rd_ready;
  token_t q_rd_data;

  rse_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_number_value (in_number_value),
    .q_valid         (q_wr_valid),
    .q_data          (q_wr_data),
    .q_ready         (q_wr_ready)
  );

  rse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rd_data),
    .rd_ready (q_rd_ready)
  );

  rse_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tok_valid           (q_rd_valid),
    .tok                 (q_rd_data),
    .tok_ready           (q_rd_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_top_value       (out_top_value),
    .out_status          (out_status),
    .out_depth           (out_depth),
    .out_expression_done (out_expression_done)
  );

  `RSE_ASSERT_NEXT(a_queue_holds_token, clk, rst_n, in_valid && in_ready, q_rd_valid, "accepted token missing from queue")
  `RSE_ASSERT_IMPLY(a_end_empties, clk, rst_n, out_valid && out_expression_done, out_depth == '0, "end token left entries on stack")
  `RSE_ASSERT_IMPLY(a_end_fault_zero, clk, rst_n, out_valid && out_expression_done && (out_status != ST_OK), out_top_value == '0, "faulted end token reports nonzero value")
  `RSE_ASSERT_IMPLY(a_divz_saturates, clk, rst_n, out_valid && (out_status == ST_DIV_ZERO), (out_top_value == Q_MAX) || (out_top_value == Q_MIN), "divide by zero not saturated")

endmodule
